// ===== rtl/itr_pkg.sv =====
// Shared types, letter codes and digit tables for the integer to Roman numeral encoder.
package itr_pkg;

  localparam int VALUE_W             = 12;
  localparam int SYMBOL_W            = 7;
  localparam int NUM_PLACES          = 4;
  localparam int DIGIT_W             = 4;
  localparam int PLACE_W             = 2;
  localparam int POS_W               = 2;
  localparam int LEN_W               = 3;
  localparam int WEIGHT_W            = 14;
  localparam int MAX_DIGIT           = 9;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  typedef logic [DIGIT_W-1:0]     digit_t;
  typedef digit_t [NUM_PLACES-1:0] digits_t;
  typedef logic [PLACE_W-1:0]     place_t;
  typedef logic [POS_W-1:0]       pos_t;
  typedef logic [LEN_W-1:0]       len_t;
  typedef logic [WEIGHT_W-1:0]    weight_t;
  typedef logic [SYMBOL_W-1:0]    symbol_t;

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_EXTRACT,
    FRONT_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    ROLE_ONE,
    ROLE_FIVE,
    ROLE_TEN
  } role_t;

  localparam place_t PLACE_ONES      = 2'd0;
  localparam place_t PLACE_TENS      = 2'd1;
  localparam place_t PLACE_HUNDREDS  = 2'd2;
  localparam place_t PLACE_THOUSANDS = 2'd3;

  localparam symbol_t CHAR_C = 7'd67;
  localparam symbol_t CHAR_D = 7'd68;
  localparam symbol_t CHAR_I = 7'd73;
  localparam symbol_t CHAR_L = 7'd76;
  localparam symbol_t CHAR_M = 7'd77;
  localparam symbol_t CHAR_V = 7'd86;
  localparam symbol_t CHAR_X = 7'd88;

  function automatic weight_t place_weight(place_t p);
    weight_t w;
    unique case (p)
      PLACE_THOUSANDS: w = 14'd1000;
      PLACE_HUNDREDS:  w = 14'd100;
      PLACE_TENS:      w = 14'd10;
      default:         w = 14'd1;
    endcase
    return w;
  endfunction

  // Number of letters one decimal digit produces at a place.
  function automatic len_t digit_len(place_t p, digit_t d);
    len_t n;
    if (p == PLACE_THOUSANDS) begin
      n = len_t'(d);
    end else begin
      unique case (d)
        4'd0:                n = 3'd0;
        4'd1, 4'd5:          n = 3'd1;
        4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
        4'd3, 4'd7:          n = 3'd3;
        4'd8:                n = 3'd4;
        default:             n = 3'd0;
      endcase
    end
    return n;
  endfunction

  // Which of the place's three letters stands at a position within the digit.
  function automatic role_t digit_role(place_t p, digit_t d, pos_t pos);
    role_t r;
    r = ROLE_ONE;
    if (p != PLACE_THOUSANDS) begin
      unique case (d)
        4'd4:                r = (pos == 2'd0) ? ROLE_ONE : ROLE_FIVE;
        4'd5:                r = ROLE_FIVE;
        4'd6, 4'd7, 4'd8:    r = (pos == 2'd0) ? ROLE_FIVE : ROLE_ONE;
        4'd9:                r = (pos == 2'd0) ? ROLE_ONE : ROLE_TEN;
        default:             r = ROLE_ONE;
      endcase
    end
    return r;
  endfunction

  function automatic symbol_t role_letter(place_t p, role_t r);
    symbol_t s;
    unique case (p)
      PLACE_THOUSANDS: s = CHAR_M;
      PLACE_HUNDREDS:  s = (r == ROLE_ONE) ? CHAR_C : ((r == ROLE_FIVE) ? CHAR_D : CHAR_M);
      PLACE_TENS:      s = (r == ROLE_ONE) ? CHAR_X : ((r == ROLE_FIVE) ? CHAR_L : CHAR_C);
      default:         s = (r == ROLE_ONE) ? CHAR_I : ((r == ROLE_FIVE) ? CHAR_V : CHAR_X);
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/itr_front.sv =====
// Front end: accepts a value and splits it into decimal digits, one place per cycle.
module itr_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [itr_pkg::VALUE_W-1:0] value,
  input  logic                        value_valid,
  output logic                        value_stall,
  output logic                        push,
  output itr_pkg::digits_t            push_digits,
  input  logic                        full
);

  itr_pkg::front_state_t        state, state_next;
  logic [itr_pkg::VALUE_W-1:0]  rem, rem_next;
  itr_pkg::place_t              place, place_next;
  itr_pkg::digits_t             digits, digits_next;

  itr_pkg::weight_t             weight;
  itr_pkg::digit_t              digit;
  itr_pkg::weight_t             taken;
  logic                         all_zero;

  // Digit of the current place: how many multiples of the weight fit in the remainder.
  always_comb begin
    weight = itr_pkg::place_weight(place);
    digit  = '0;
    for (int k = 1; k <= itr_pkg::MAX_DIGIT; k++) begin
      if ({2'b00, rem} >= itr_pkg::weight_t'(k) * weight) begin
        digit = itr_pkg::digit_t'(k);
      end
    end
    taken = itr_pkg::weight_t'(digit) * weight;
  end

  assign all_zero = (digits == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itr_pkg::FRONT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    rem    <= rem_next;
    place  <= place_next;
    digits <= digits_next;
  end

  always_comb begin
    state_next  = state;
    rem_next    = rem;
    place_next  = place;
    digits_next = digits;
    value_stall = 1'b1;
    push        = 1'b0;
    push_digits = digits;
    unique case (state)
      itr_pkg::FRONT_IDLE: begin
        value_stall = 1'b0;
        if (value_valid) begin
          rem_next    = value;
          place_next  = itr_pkg::PLACE_THOUSANDS;
          digits_next = '0;
          state_next  = itr_pkg::FRONT_EXTRACT;
        end
      end
      itr_pkg::FRONT_EXTRACT: begin
        digits_next[place] = digit;
        rem_next           = itr_pkg::VALUE_W'({2'b00, rem} - taken);
        if (place == itr_pkg::PLACE_ONES) begin
          state_next = itr_pkg::FRONT_PUSH;
        end else begin
          place_next = place - 1'b1;
        end
      end
      itr_pkg::FRONT_PUSH: begin
        // A zero request has no letters and is dropped here.
        if (all_zero) begin
          state_next = itr_pkg::FRONT_IDLE;
        end else if (!full) begin
          push       = 1'b1;
          state_next = itr_pkg::FRONT_IDLE;
        end
      end
      default: state_next = itr_pkg::FRONT_IDLE;
    endcase
  end

endmodule

// ===== rtl/itr_queue.sv =====
// Short queue of digit records between the front end and the letter emitter.
module itr_queue #(
  parameter int DEPTH = itr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  itr_pkg::digits_t push_digits,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output itr_pkg::digits_t head_digits
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  itr_pkg::digits_t  entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full        = (count == CNT_W'(DEPTH));
  assign head_valid  = (count != '0);
  assign head_digits = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_digits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue read while empty");

  a_never_empty_record: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (head_digits != '0))
    else $error("queue holds a record with no letters");

endmodule

// ===== rtl/itr_back.sv =====
// Back end: walks the digit record at the queue head and emits one letter per cycle while the output is not stalled.
module itr_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         head_valid,
  input  itr_pkg::digits_t             head_digits,
  output logic                         pop,
  output logic [itr_pkg::SYMBOL_W-1:0] symbol,
  output logic                         last,
  output logic                         symbol_valid,
  input  logic                         symbol_stall
);

  logic             started;
  itr_pkg::place_t  place;
  itr_pkg::pos_t    pos;

  itr_pkg::place_t  top_place, cur_place, next_place;
  itr_pkg::digit_t  cur_digit;
  itr_pkg::len_t    cur_len;
  itr_pkg::role_t   cur_role;
  itr_pkg::symbol_t cur_symbol;
  logic             lower_nonzero;
  logic             digit_end;
  logic             final_letter;
  logic             fire;

  always_comb begin
    top_place = itr_pkg::PLACE_ONES;
    for (int i = 0; i < itr_pkg::NUM_PLACES; i++) begin
      if (head_digits[i] != '0) begin
        top_place = itr_pkg::place_t'(i);
      end
    end
    cur_place = started ? place : top_place;

    // Highest nonzero place below the current one, if any.
    lower_nonzero = 1'b0;
    next_place    = itr_pkg::PLACE_ONES;
    for (int i = 0; i < itr_pkg::NUM_PLACES; i++) begin
      if ((itr_pkg::place_t'(i) < cur_place) && (head_digits[i] != '0)) begin
        lower_nonzero = 1'b1;
        next_place    = itr_pkg::place_t'(i);
      end
    end

    cur_digit    = head_digits[cur_place];
    cur_len      = itr_pkg::digit_len(cur_place, cur_digit);
    cur_role     = itr_pkg::digit_role(cur_place, cur_digit, pos);
    cur_symbol   = itr_pkg::role_letter(cur_place, cur_role);
    digit_end    = ({1'b0, pos} == cur_len - 1'b1);
    final_letter = digit_end && !lower_nonzero;
  end

  assign fire = head_valid && (!symbol_valid || !symbol_stall);
  assign pop  = fire && final_letter;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_valid <= 1'b0;
      started      <= 1'b0;
      pos          <= '0;
    end else begin
      if (fire) begin
        symbol_valid <= 1'b1;
        if (final_letter) begin
          started <= 1'b0;
          pos     <= '0;
        end else if (digit_end) begin
          started <= 1'b1;
          pos     <= '0;
        end else begin
          started <= 1'b1;
          pos     <= pos + 1'b1;
        end
      end else if (!symbol_stall) begin
        symbol_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      symbol <= cur_symbol;
      last   <= final_letter;
      place  <= digit_end ? next_place : cur_place;
    end
  end

  a_legal_letter: assert property (@(posedge clk) disable iff (rst)
    symbol_valid |-> (symbol == itr_pkg::CHAR_C || symbol == itr_pkg::CHAR_D ||
                      symbol == itr_pkg::CHAR_I || symbol == itr_pkg::CHAR_L ||
                      symbol == itr_pkg::CHAR_M || symbol == itr_pkg::CHAR_V ||
                      symbol == itr_pkg::CHAR_X))
    else $error("emitted code is not a numeral letter");

  a_pos_in_digit: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> ({1'b0, pos} < cur_len))
    else $error("letter position runs past the digit");

  a_mid_record_place: assert property (@(posedge clk) disable iff (rst)
    (head_valid && started) |-> (head_digits[place] != '0))
    else $error("walk stands on a zero digit");

endmodule

// ===== rtl/integer_to_roman_encoder_top.sv =====
// Top level of the integer to Roman numeral encoder: front end, digit queue and letter emitter.
//
//   Channel   Signals                       Direction   Payload
//   request   value_valid / value_stall     in          value[11:0]
//   letter    symbol_valid / symbol_stall   out         symbol[6:0], last
//
// The front end takes one request at a time: one step to accept, four digit steps
// (one per decimal place through a shared compare unit) and one to push the digits,
// which waits while the queue is full. The emitter gives one letter per cycle while
// the letter output is not stalled.
// Reset clears the front state machine, the queue pointers and the output valid.
// A stalled letter output holds the emitter; the queue lets the front end run ahead.
module integer_to_roman_encoder_top #(
  parameter int QUEUE_DEPTH = itr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [itr_pkg::VALUE_W-1:0]  value,
  input  logic                         value_valid,
  output logic                         value_stall,
  output logic [itr_pkg::SYMBOL_W-1:0] symbol,
  output logic                         last,
  output logic                         symbol_valid,
  input  logic                         symbol_stall
);

  logic             push, full, pop, head_valid;
  itr_pkg::digits_t push_digits, head_digits;

  itr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .push        (push),
    .push_digits (push_digits),
    .full        (full)
  );

  itr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_digits (push_digits),
    .full        (full),
    .pop         (pop),
    .head_valid  (head_valid),
    .head_digits (head_digits)
  );

  itr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_digits  (head_digits),
    .pop          (pop),
    .symbol       (symbol),
    .last         (last),
    .symbol_valid (symbol_valid),
    .symbol_stall (symbol_stall)
  );

endmodule
